// ===== sv/pcx_rle_decoder_assert.svh =====
// assertion macros used by the decoder datapath module
// each expects clk and rst_n in scope
`ifndef PCX_RLE_DECODER_ASSERT_SVH
`define PCX_RLE_DECODER_ASSERT_SVH

// same-cycle implication
`define PCX_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pcxrle_pkg.sv =====
`default_nettype none

package pcxrle_pkg;

    localparam int DEF_ADDR_BITS = 24;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int BPL_W    = 16;
    localparam int IMG_W    = 24;
    localparam int OFFSET_W = 18;
    localparam int PLANE_W  = 2;
    localparam int OADDR_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [BYTE_W-1:0]  RUN_MARK   = 8'hc0;
    localparam logic [BYTE_W-1:0]  COUNT_MASK = 8'h3f;
    localparam logic [PLANE_W-1:0] PLANE_STEP = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THREE_PLANES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES    = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_start;
        logic run_last;
        logic out_full;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/pcxrle_ctrl.sv =====
`default_nettype none

module pcxrle_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               m_tready,
    input  wire pcxrle_pkg::stat_t  stat,
    output pcxrle_pkg::cmd_t        cmd,
    output logic                    s_tready
);

    pcxrle_pkg::state_t state_reg;
    pcxrle_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcxrle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcxrle_pkg::ST_IDLE:
            begin
                if (s_tvalid && stat.run_start)
                begin
                    state_next = pcxrle_pkg::ST_RUN;
                end
            end
            pcxrle_pkg::ST_RUN:
            begin
                if ((!stat.out_full || m_tready) && stat.run_last)
                begin
                    state_next = pcxrle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcxrle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            pcxrle_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            pcxrle_pkg::ST_RUN:
            begin
                // one byte per cycle whenever the output register can take it
                cmd.step = !stat.out_full || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pcxrle_dp.sv =====
`default_nettype none

`include "pcx_rle_decoder_assert.svh"

module pcxrle_dp
#(
    parameter int ADDR_BITS = pcxrle_pkg::DEF_ADDR_BITS
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [pcxrle_pkg::BYTE_W-1:0]         data_byte,
    input  wire logic                                  start_image,
    input  wire logic                                  m_tready,
    input  wire pcxrle_pkg::cmd_t                      cmd,
    output pcxrle_pkg::stat_t                          stat,
    output logic                                       out_valid,
    output logic [pcxrle_pkg::OADDR_W-1:0]             out_addr,
    output logic [pcxrle_pkg::BYTE_W-1:0]              out_value,
    output logic                                       out_last,
    output logic                                       out_done
);

    localparam int LW = (ADDR_BITS > pcxrle_pkg::OADDR_W) ? ADDR_BITS : pcxrle_pkg::OADDR_W;

    // configuration
    logic                                three_planes_reg;
    logic [pcxrle_pkg::BPL_W-1:0]        bpl_reg;
    logic [pcxrle_pkg::IMG_W-1:0]        img_reg;

    // decode and position state
    logic                                awaiting_reg,  awaiting_next;
    logic [pcxrle_pkg::COUNT_W-1:0]      pending_reg,   pending_next;
    logic [pcxrle_pkg::COUNT_W-1:0]      remaining_reg, remaining_next;
    logic [pcxrle_pkg::IMG_W-1:0]        produced_reg,  produced_next;
    logic [pcxrle_pkg::OFFSET_W-1:0]     offset_reg,    offset_next;
    logic [ADDR_BITS-1:0]                lstart_reg,    lstart_next;
    logic [pcxrle_pkg::PLANE_W-1:0]      plane_reg,     plane_next;
    logic [pcxrle_pkg::BYTE_W-1:0]       value_reg,     value_next;
    logic                                out_valid_reg, out_valid_next;

    logic [pcxrle_pkg::OADDR_W-1:0]      oaddr_reg;
    logic [pcxrle_pkg::BYTE_W-1:0]       ovalue_reg;
    logic                                olast_reg;
    logic                                odone_reg;

    // accept-side decode
    logic [pcxrle_pkg::IMG_W-1:0]        prod_eff;
    logic                                awaiting_eff;
    logic [pcxrle_pkg::COUNT_W-1:0]      pending_eff;
    logic                                done_eff;
    logic                                is_count;
    logic [pcxrle_pkg::COUNT_W-1:0]      run_cnt;
    logic                                run_start;

    // step-side address arithmetic
    logic [pcxrle_pkg::OFFSET_W-1:0]     line_len;
    logic [pcxrle_pkg::OFFSET_W-1:0]     off_inc;
    logic                                line_wrap;
    logic [pcxrle_pkg::PLANE_W-1:0]      plane_inc;
    logic [LW-1:0]                       addr_sum;
    logic [LW-1:0]                       prod_w;
    logic [LW-1:0]                       lstart_sum;
    logic [ADDR_BITS-1:0]                addr_a;
    logic [LW-1:0]                       addr_w;
    logic [pcxrle_pkg::IMG_W-1:0]        produced_inc;
    logic                                done_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_planes_reg <= 1'b0;
            bpl_reg          <= pcxrle_pkg::BPL_W'(1);
            img_reg          <= pcxrle_pkg::IMG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pcxrle_pkg::REG_THREE_PLANES:   three_planes_reg <= cfg_data[0];
                pcxrle_pkg::REG_BYTES_PER_LINE: bpl_reg <= cfg_data[pcxrle_pkg::BPL_W-1:0];
                pcxrle_pkg::REG_IMAGE_BYTES:    img_reg <= cfg_data[pcxrle_pkg::IMG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prod_eff     = start_image ? '0 : produced_reg;
        awaiting_eff = start_image ? 1'b0 : awaiting_reg;
        pending_eff  = start_image ? '0 : pending_reg;
        done_eff     = prod_eff >= img_reg;
        is_count     = (data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
        if (awaiting_eff)
        begin
            run_cnt = pending_eff;
        end
        else if (is_count)
        begin
            run_cnt = '0;
        end
        else
        begin
            run_cnt = pcxrle_pkg::COUNT_W'(1);
        end
        run_start = !done_eff && (run_cnt != '0);
    end

    always_comb
    begin
        line_len     = ({2'b00, bpl_reg} << 1) + {2'b00, bpl_reg};
        off_inc      = offset_reg + pcxrle_pkg::OFFSET_W'(pcxrle_pkg::PLANE_STEP);
        line_wrap    = off_inc >= line_len;
        plane_inc    = (plane_reg >= 2'd2) ? 2'd0 : plane_reg + 2'd1;
        addr_sum     = LW'(lstart_reg) + LW'(offset_reg);
        prod_w       = LW'(produced_reg);
        lstart_sum   = LW'(lstart_reg) + LW'(line_len);
        addr_a       = three_planes_reg ? addr_sum[ADDR_BITS-1:0] : prod_w[ADDR_BITS-1:0];
        addr_w       = LW'(addr_a);
        produced_inc = produced_reg + pcxrle_pkg::IMG_W'(1);
        done_step    = produced_inc >= img_reg;
        stat.run_start = run_start;
        stat.run_last  = (remaining_reg == pcxrle_pkg::COUNT_W'(1)) || done_step;
        stat.out_full  = out_valid_reg;
    end

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        pending_next   = pending_reg;
        remaining_next = remaining_reg;
        produced_next  = produced_reg;
        offset_next    = offset_reg;
        lstart_next    = lstart_reg;
        plane_next     = plane_reg;
        value_next     = value_reg;

        if (cmd.accept)
        begin
            if (start_image)
            begin
                awaiting_next = 1'b0;
                pending_next  = '0;
                produced_next = '0;
                offset_next   = '0;
                lstart_next   = '0;
                plane_next    = pcxrle_pkg::PLANE_W'(1);
            end
            // a finished image swallows bytes until the next start
            if (!done_eff)
            begin
                if (awaiting_eff)
                begin
                    awaiting_next  = 1'b0;
                    remaining_next = pending_eff;
                    value_next     = data_byte;
                end
                else if (is_count)
                begin
                    awaiting_next = 1'b1;
                    pending_next  = data_byte[pcxrle_pkg::COUNT_W-1:0];
                end
                else
                begin
                    remaining_next = pcxrle_pkg::COUNT_W'(1);
                    value_next     = data_byte;
                end
            end
        end
        else if (cmd.step)
        begin
            remaining_next = remaining_reg - pcxrle_pkg::COUNT_W'(1);
            produced_next  = produced_inc;
            if (three_planes_reg)
            begin
                if (line_wrap)
                begin
                    offset_next = pcxrle_pkg::OFFSET_W'(plane_reg);
                    plane_next  = plane_inc;
                    // back to plane 0 means a new scan line
                    if (plane_reg == '0)
                    begin
                        lstart_next = lstart_sum[ADDR_BITS-1:0];
                    end
                end
                else
                begin
                    offset_next = off_inc;
                end
            end
        end

        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            pending_reg   <= '0;
            remaining_reg <= '0;
            produced_reg  <= '0;
            offset_reg    <= '0;
            lstart_reg    <= '0;
            plane_reg     <= pcxrle_pkg::PLANE_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            pending_reg   <= pending_next;
            remaining_reg <= remaining_next;
            produced_reg  <= produced_next;
            offset_reg    <= offset_next;
            lstart_reg    <= lstart_next;
            plane_reg     <= plane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (cmd.step)
        begin
            oaddr_reg  <= addr_w[pcxrle_pkg::OADDR_W-1:0];
            ovalue_reg <= value_reg;
            olast_reg  <= stat.run_last;
            odone_reg  <= done_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = oaddr_reg;
    assign out_value = ovalue_reg;
    assign out_last  = olast_reg;
    assign out_done  = odone_reg;

    `PCX_ASSERT_HOLD(a_step_has_count, cmd.step, remaining_reg != '0, "step with empty run count")
    `PCX_ASSERT_HOLD(a_no_overwrite, out_valid_reg && !m_tready, !cmd.step, "waiting beat overwritten")
    `PCX_ASSERT_HOLD(a_plane_range, 1'b1, plane_reg != 2'd3, "plane counter out of range")
    `PCX_ASSERT_NEXT(a_start_clears, cmd.accept && start_image, offset_reg == '0 && plane_reg == 2'd1 && lstart_reg == '0 && produced_reg == '0, "start of image did not clear position")

endmodule

`default_nettype wire

// ===== sv/pcx_rle_decoder.sv =====
// PCX run-length decoder. Takes the compressed pixel stream one byte per beat
// on the slave side and gives decoded bytes with their buffer addresses on the
// master side. A literal byte is accepted, then goes out as one output byte;
// a count byte is only accepted; a run of n bytes holds the input while one
// byte per cycle, when the output register can take it, goes out through the
// single output register, which sets the rate. Input is taken again while the
// last byte of a run still waits there. The user must write configuration
// through the cfg port while no run is in progress; it is not enforced.
`default_nettype none

module pcx_rle_decoder
#(
    parameter int ADDR_BITS = pcxrle_pkg::DEF_ADDR_BITS
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [pcxrle_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [7:0]                            s_tdata,   // data_byte
    input  wire logic [0:0]                            s_tuser,   // start_image
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [31:0]                                m_tdata,   // out_addr, out_value
    output logic                                       m_tlast,
    output logic [0:0]                                 m_tuser    // out_done
);

    pcxrle_pkg::cmd_t  cmd;
    pcxrle_pkg::stat_t stat;

    logic [pcxrle_pkg::OADDR_W-1:0] out_addr;
    logic [pcxrle_pkg::BYTE_W-1:0]  out_value;
    logic                           out_done;

    pcxrle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    pcxrle_dp
    #(
        .ADDR_BITS (ADDR_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .data_byte   (s_tdata),
        .start_image (s_tuser[0]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_addr    (out_addr),
        .out_value   (out_value),
        .out_last    (m_tlast),
        .out_done    (out_done)
    );

    assign m_tdata = {out_value, out_addr};
    assign m_tuser = out_done;

endmodule

`default_nettype wire
